### design/windowed_scaled_scatter_add_macros.svh
// Assertion macros shared by the checker of the windowed scaled scatter-add table.
// Depends on nothing; included by the files that carry assertions.
`ifndef WINDOWED_SCALED_SCATTER_ADD_MACROS_SVH
`define WINDOWED_SCALED_SCATTER_ADD_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSSA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSSA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define WSSA_ASSERT_ALL(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/wssa_pkg.sv
// Shared types and constants of the windowed scaled scatter-add table.
// Used by the configuration block and the top level; depends on nothing.
`default_nettype none

package wssa_pkg;

    // Default geometry of the table.
    localparam int TABLE_WORDS_DEF = 4096;
    localparam int WORD_BITS_DEF   = 32;

    // Width of a computed table address: a 13 by 13 bit product plus an element.
    localparam int CALC_ADDR_W = 27;

    // Command codes.
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_SCATTER = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_ELEMENT = 2'd2;
    localparam logic [1:0] ST_ADDRESS = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SLICES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_WORDS   = 3'd3;

    // Configuration register file contents.
    typedef struct packed {
        logic [31:0] scale_factor;
        logic [30:0] window_start;
        logic [12:0] window_slices;
        logic [12:0] slice_words;
    } cfg_t;

endpackage

`default_nettype wire

### design/wssa_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; holds the table words of the scatter-add block.
`default_nettype none

module wssa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/wssa_cfg.sv
// Configuration register file of the windowed scaled scatter-add table.
// Depends on wssa_pkg for the register indexes and the cfg_t type.
`default_nettype none

module wssa_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [wssa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data,
    output wssa_pkg::cfg_t                      cfg
);

    wssa_pkg::cfg_t cfg_reg;
    wssa_pkg::cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index; unknown indexes leave everything unchanged.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                wssa_pkg::CFG_SCALE_FACTOR:  cfg_next.scale_factor  = cfg_data;
                wssa_pkg::CFG_WINDOW_START:  cfg_next.window_start  = cfg_data[30:0];
                wssa_pkg::CFG_WINDOW_SLICES: cfg_next.window_slices = cfg_data[12:0];
                wssa_pkg::CFG_SLICE_WORDS:   cfg_next.slice_words   = cfg_data[12:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale_factor  <= 32'd1;
            cfg_reg.window_start  <= 31'd0;
            cfg_reg.window_slices <= 13'd0;
            cfg_reg.slice_words   <= 13'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### design/windowed_scaled_scatter_add.sv
// Windowed scaled scatter-add table: top level with sequencer, datapath and table RAM.
// Sequence: an accepted item passes the calc, multiply and address states, then a
// read-modify-write through the registered-read table RAM; in the done state its
// result goes onto m_valid once the output is free. Items are worked one at a time.
// Reset: synchronous, active low; clears control, output valid and configuration.
// Table contents are not cleared and are undefined until written.
`default_nettype none

module windowed_scaled_scatter_add #(
    parameter int TABLE_WORDS = wssa_pkg::TABLE_WORDS_DEF,
    parameter int WORD_BITS   = wssa_pkg::WORD_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input items.
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_cmd,
    input  wire logic [11:0]                    s_word_address,
    input  wire logic [30:0]                    s_slice_index,
    input  wire logic [11:0]                    s_element_position,
    input  wire logic signed [31:0]             s_data_value,
    // Result items.
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [31:0]                  m_read_word,
    output logic [1:0]                          m_status_code,
    // Configuration writes.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [wssa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    localparam int ADDR_W = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
    localparam int CAW    = wssa_pkg::CALC_ADDR_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CALC = 6'b000010,
        S_MUL  = 6'b000100,
        S_ADDR = 6'b001000,
        S_RMW  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    wssa_pkg::cfg_t cfg;

    // Item registers.
    logic [1:0]           cmd_reg;
    logic [11:0]          word_address_reg;
    logic [30:0]          slice_reg;
    logic [11:0]          elem_reg;
    logic [31:0]          data_reg;
    // Work registers.
    logic [12:0]          local_reg;
    logic [1:0]           status_reg, status_next;
    logic [25:0]          slice_base_reg;
    logic [31:0]          scaled_reg;
    logic [ADDR_W-1:0]    mem_addr_reg;
    logic                 mem_ok_reg;
    logic signed [31:0]   result_word_reg;
    // Output registers.
    logic                 m_valid_reg;
    logic signed [31:0]   m_read_word_reg;
    logic [1:0]           m_status_code_reg;

    // Combinational terms.
    logic [31:0]          local_diff;
    logic [CAW-1:0]       addr_calc;
    logic                 addr_in_range;
    logic                 mem_ok;
    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [WORD_BITS-1:0] ram_rd_data;
    logic                 in_accept;
    logic                 out_load;

    // Configuration registers.
    wssa_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Table storage.
    wssa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TABLE_WORDS)
    ) u_table (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (addr_calc[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_load  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    assign m_valid       = m_valid_reg;
    assign m_read_word   = m_read_word_reg;
    assign m_status_code = m_status_code_reg;

    // Window subtraction wraps at 32 bits, so slices below the window land far outside it.
    assign local_diff = {1'b0, slice_reg} - {1'b0, cfg.window_start};

    // Early status: window and element checks for scatter-add items.
    always_comb begin
        status_next = wssa_pkg::ST_DONE;
        if (cmd_reg == wssa_pkg::CMD_SCATTER) begin
            if (local_diff >= {19'd0, cfg.window_slices}) begin
                status_next = wssa_pkg::ST_OUTSIDE;
            end else if ({1'b0, elem_reg} >= cfg.slice_words) begin
                status_next = wssa_pkg::ST_ELEMENT;
            end
        end
    end

    // Table address and range check.
    always_comb begin
        if (cmd_reg == wssa_pkg::CMD_SCATTER) begin
            addr_calc = {1'b0, slice_base_reg} + {{(CAW-12){1'b0}}, elem_reg};
        end else begin
            addr_calc = {{(CAW-12){1'b0}}, word_address_reg};
        end
    end

    assign addr_in_range = addr_calc < CAW'(TABLE_WORDS);
    assign mem_ok = (status_reg == wssa_pkg::ST_DONE) && addr_in_range &&
                    (cmd_reg == wssa_pkg::CMD_WRITE || cmd_reg == wssa_pkg::CMD_READ ||
                     cmd_reg == wssa_pkg::CMD_SCATTER);

    // RAM ports: plain writes in the address stage, the add write-back in the read-modify-write state.
    assign ram_rd_en = (state_reg == S_ADDR) && mem_ok &&
                       (cmd_reg == wssa_pkg::CMD_READ || cmd_reg == wssa_pkg::CMD_SCATTER);

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = addr_calc[ADDR_W-1:0];
        ram_wr_data = data_reg[WORD_BITS-1:0];
        if (state_reg == S_ADDR) begin
            ram_wr_en = mem_ok && (cmd_reg == wssa_pkg::CMD_WRITE);
        end else if (state_reg == S_RMW) begin
            ram_wr_en   = mem_ok_reg && (cmd_reg == wssa_pkg::CMD_SCATTER);
            ram_wr_addr = mem_addr_reg;
            ram_wr_data = ram_rd_data + scaled_reg[WORD_BITS-1:0];
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_accept) state_next = S_CALC;
            S_CALC: state_next = S_MUL;
            S_MUL:  state_next = S_ADDR;
            S_ADDR: state_next = S_RMW;
            S_RMW:  state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cmd_reg          <= s_cmd;
            word_address_reg <= s_word_address;
            slice_reg        <= s_slice_index;
            elem_reg         <= s_element_position;
            data_reg         <= s_data_value;
        end
        if (state_reg == S_CALC) begin
            local_reg  <= local_diff[12:0];
            status_reg <= status_next;
        end
        if (state_reg == S_MUL) begin
            slice_base_reg <= 26'(local_reg) * 26'(cfg.slice_words);
            scaled_reg     <= cfg.scale_factor * data_reg;
        end
        if (state_reg == S_ADDR) begin
            mem_addr_reg <= addr_calc[ADDR_W-1:0];
            mem_ok_reg   <= mem_ok;
            if (status_reg == wssa_pkg::ST_DONE && !addr_in_range &&
                (cmd_reg == wssa_pkg::CMD_WRITE || cmd_reg == wssa_pkg::CMD_READ ||
                 cmd_reg == wssa_pkg::CMD_SCATTER)) begin
                status_reg <= wssa_pkg::ST_ADDRESS;
            end
        end
        if (state_reg == S_RMW) begin
            if (mem_ok_reg && cmd_reg == wssa_pkg::CMD_READ) begin
                result_word_reg <= 32'($signed(ram_rd_data));
            end else begin
                result_word_reg <= 32'sd0;
            end
        end
        if (out_load) begin
            m_read_word_reg   <= result_word_reg;
            m_status_code_reg <= status_reg;
        end
    end

endmodule

`default_nettype wire

### design/wssa_checker.sv
// Port-level checker of the windowed scaled scatter-add table, bound to the top level.
// Depends on wssa_pkg and the assertion macros header.
`default_nettype none
`include "windowed_scaled_scatter_add_macros.svh"

module wssa_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [31:0] m_read_word,
    input wire logic [1:0]         m_status_code
);

    // A result that is not taken holds its value.
    `WSSA_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_read_word) && $stable(m_status_code), "result changed while stalled")

    // Any failed or skipped item reports a zero word.
    `WSSA_ASSERT_IMP(a_fail_zero, aclk, aresetn, m_valid && m_status_code != wssa_pkg::ST_DONE, m_read_word == 32'sd0, "nonzero word with failing status")

    // Items are worked one at a time: no new item right after one is taken.
    `WSSA_ASSERT_NXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready, "input ready right after an accepted item")

    // Reset leaves no result pending.
    `WSSA_ASSERT_ALL(a_reset_clear, aclk, !aresetn, !m_valid, "result valid after reset")

endmodule

bind windowed_scaled_scatter_add wssa_checker u_wssa_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_read_word   (m_read_word),
    .m_status_code (m_status_code)
);

`default_nettype wire

### sim/windowed_scaled_scatter_add_tb.sv
// Self-checking testbench for the windowed scaled scatter-add table.
// Depends on wssa_pkg and windowed_scaled_scatter_add; predicts every result
// from its own copy of the table and the configuration registers.
`timescale 1ns / 100ps

module windowed_scaled_scatter_add_tb;

    import wssa_pkg::*;

    localparam int TABLE_WORDS     = TABLE_WORDS_DEF;
    localparam int SETTLE_CYCLES   = 10;
    localparam int HOLD_CYCLES     = 150;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int REPORT_LIMIT    = 10;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int FLOOD_ITEMS     = 60;

    // The one command code that the block leaves unused.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [11:0]        word_address;
        logic [30:0]        slice_index;
        logic [11:0]        element_position;
        logic signed [31:0] data_value;
    } table_op_t;

    typedef struct packed {
        logic signed [31:0] read_word;
        logic [1:0]         status_code;
    } table_reply_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_cmd;
    logic [11:0]        s_word_address;
    logic [30:0]        s_slice_index;
    logic [11:0]        s_element_position;
    logic signed [31:0] s_data_value;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_read_word;
    logic [1:0]         m_status_code;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]        cfg_data;

    // Shadow of the table and of the configuration registers.
    logic [31:0]  table_mirror [TABLE_WORDS];
    bit           written_mask [TABLE_WORDS];
    cfg_t         cfg_shadow;
    table_reply_t expected_replies [$];

    int unsigned err_count   = 0;
    int unsigned reply_count = 0;
    int unsigned idle_cycles = 0;
    bit          tx_burst     = 1'b0;
    bit          tx_flood     = 1'b0;
    bit          rx_burst     = 1'b0;
    bit          hold_request = 1'b0;

    windowed_scaled_scatter_add u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_word_address     (s_word_address),
        .s_slice_index      (s_slice_index),
        .s_element_position (s_element_position),
        .s_data_value       (s_data_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_read_word        (m_read_word),
        .m_status_code      (m_status_code),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic table_op_t make_op(input logic [1:0] cmd, input logic [11:0] addr,
                                          input logic [30:0] slice, input logic [11:0] elem,
                                          input logic [31:0] data);
        table_op_t op;
        op.cmd              = cmd;
        op.word_address     = addr;
        op.slice_index      = slice;
        op.element_position = elem;
        op.data_value       = data;
        return op;
    endfunction

    // Mostly full-range words, with a share of small values around zero.
    function automatic logic [31:0] draw_value();
        logic [31:0] v;
        if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 16) - 8;
        else v = $urandom;
        return v;
    endfunction

    // Resolves a scatter-add against the window; target is valid only for ST_DONE.
    function automatic logic [1:0] locate_update(input table_op_t op, output logic [11:0] target);
        logic [31:0] local_slice;
        logic [63:0] span;
        logic [63:0] stride;
        logic [63:0] flat;
        target = '0;
        // A slice below the window start wraps to a huge local index.
        local_slice = {1'b0, op.slice_index} - {1'b0, cfg_shadow.window_start};
        if (local_slice >= cfg_shadow.window_slices) return ST_OUTSIDE;
        if (op.element_position >= cfg_shadow.slice_words) return ST_ELEMENT;
        span   = 64'(local_slice);
        stride = 64'(cfg_shadow.slice_words);
        flat   = span * stride + 64'(op.element_position);
        if (flat >= TABLE_WORDS) return ST_ADDRESS;
        target = flat[11:0];
        return ST_DONE;
    endfunction

    // Applies one accepted item to the shadow table and returns its result.
    // Words are 32 bits wide, so no masking or sign extension is needed.
    function automatic table_reply_t apply_table_op(input table_op_t op);
        table_reply_t reply;
        logic [11:0]  tgt;
        logic [31:0]  scaled;
        reply = '0;
        case (op.cmd)
            CMD_WRITE: begin
                if (op.word_address < TABLE_WORDS) begin
                    table_mirror[op.word_address] = op.data_value;
                    written_mask[op.word_address] = 1'b1;
                end else begin
                    reply.status_code = ST_ADDRESS;
                end
            end
            CMD_READ: begin
                if (op.word_address < TABLE_WORDS) reply.read_word = table_mirror[op.word_address];
                else reply.status_code = ST_ADDRESS;
            end
            CMD_SCATTER: begin
                reply.status_code = locate_update(op, tgt);
                if (reply.status_code == ST_DONE) begin
                    scaled = cfg_shadow.scale_factor * op.data_value;
                    table_mirror[tgt] = table_mirror[tgt] + scaled;
                end
            end
            default: ;
        endcase
        return reply;
    endfunction

    // Offers one item after a random gap and records its result once accepted.
    task automatic send_op(input table_op_t op);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
        gap = (tx_burst || tx_flood) ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_cmd              <= op.cmd;
        s_word_address     <= op.word_address;
        s_slice_index      <= op.slice_index;
        s_element_position <= op.element_position;
        s_data_value       <= op.data_value;
        do @(posedge aclk); while (!s_ready);
        expected_replies.push_back(apply_table_op(op));
    endtask

    // Writes a random word first wherever a read or an add would touch an unwritten entry.
    task automatic send_guarded(input table_op_t op);
        logic [11:0] tgt;
        bit          fresh;
        fresh = 1'b0;
        if (op.cmd == CMD_READ) begin
            tgt   = op.word_address;
            fresh = !written_mask[tgt];
        end else if (op.cmd == CMD_SCATTER) begin
            fresh = (locate_update(op, tgt) == ST_DONE) && !written_mask[tgt];
        end
        if (fresh) send_op(make_op(CMD_WRITE, tgt, 31'd0, 12'd0, draw_value()));
        send_op(op);
    endtask

    // Stops offering items and waits until every expected result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_replies.size() != 0);
    endtask

    task automatic cfg_write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SCALE_FACTOR:  cfg_shadow.scale_factor  = value;
            CFG_WINDOW_START:  cfg_shadow.window_start  = value[30:0];
            CFG_WINDOW_SLICES: cfg_shadow.window_slices = value[12:0];
            CFG_SLICE_WORDS:   cfg_shadow.slice_words   = value[12:0];
            default: ;
        endcase
    endtask

    // Reprograms all four registers once the block has gone idle.
    task automatic program_table_window(input logic [31:0] scale, input logic [30:0] start,
                                        input logic [12:0] slices, input logic [12:0] words);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_write_reg(CFG_SCALE_FACTOR, scale);
        cfg_write_reg(CFG_WINDOW_START, {1'b0, start});
        cfg_write_reg(CFG_WINDOW_SLICES, {19'd0, slices});
        cfg_write_reg(CFG_SLICE_WORDS, {19'd0, words});
        cfg_valid <= 1'b0;
    endtask

    // Random item shaped by the current window: mostly in-window adds.
    function automatic table_op_t draw_table_op();
        table_op_t   op;
        int unsigned pick;
        int unsigned area;
        int unsigned slices;
        int unsigned words;
        logic [31:0] slice_w;
        slices = 32'(cfg_shadow.window_slices);
        words  = 32'(cfg_shadow.slice_words);
        area   = slices * words;
        if (area > TABLE_WORDS) area = TABLE_WORDS;
        op = make_op(CMD_WRITE, 12'd0, 31'd0, 12'd0, draw_value());
        if (area != 0 && $urandom_range(0, 2) != 0)
            op.word_address = 12'($urandom_range(0, area - 1));
        else op.word_address = 12'($urandom_range(0, 4095));
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            op.cmd = CMD_WRITE;
        end else if (pick < 30) begin
            op.cmd = CMD_READ;
        end else if (pick < 85) begin
            op.cmd = CMD_SCATTER;
            slice_w = {1'b0, cfg_shadow.window_start};
            if (slices != 0) slice_w = slice_w + $urandom_range(0, slices - 1);
            op.slice_index      = slice_w[30:0];
            op.element_position = (words != 0) ? 12'($urandom_range(0, words - 1)) : 12'd0;
        end else if (pick < 95) begin
            // Adds that miss the window or the slice, or land at its edges.
            op.cmd = CMD_SCATTER;
            slice_w = {1'b0, cfg_shadow.window_start};
            case ($urandom_range(0, 2))
                0:       slice_w = $urandom;
                1:       slice_w = slice_w - $urandom_range(1, 4);
                default: slice_w = slice_w + slices + $urandom_range(0, 3);
            endcase
            op.slice_index      = slice_w[30:0];
            op.element_position = 12'($urandom_range(0, 4095));
        end else begin
            slice_w             = $urandom;
            op.cmd              = CMD_UNUSED;
            op.slice_index      = slice_w[30:0];
            op.element_position = 12'($urandom_range(0, 4095));
        end
        return op;
    endfunction

    // Plain writes and reads at the address extremes, the unused command, and
    // an add under the reset window, which holds no slices.
    task automatic test_table_access();
        send_guarded(make_op(CMD_WRITE, 12'd0, 31'd0, 12'd0, 32'h7FFF_FFFF));
        send_guarded(make_op(CMD_WRITE, 12'd4095, 31'd0, 12'd0, 32'h8000_0000));
        send_guarded(make_op(CMD_WRITE, 12'hAAA, 31'd0, 12'd0, 32'h5555_5555));
        send_guarded(make_op(CMD_READ, 12'd0, 31'd0, 12'd0, 32'd0));
        send_guarded(make_op(CMD_READ, 12'd4095, 31'd0, 12'd0, 32'd0));
        send_guarded(make_op(CMD_UNUSED, 12'hFFF, 31'h7FFF_FFFF, 12'hFFF, 32'hFFFF_FFFF));
        send_guarded(make_op(CMD_SCATTER, 12'd0, 31'd0, 12'd0, 32'd5));
    endtask

    // Slices just below and past the window, an element past the slice, and hits.
    task automatic test_window_edges();
        program_table_window(32'd3, 31'd10, 13'd4, 13'd8);
        send_guarded(make_op(CMD_SCATTER, 12'd0, 31'd9, 12'd0, 32'd1));
        send_guarded(make_op(CMD_SCATTER, 12'd0, 31'd14, 12'd0, 32'd1));
        send_guarded(make_op(CMD_SCATTER, 12'd0, 31'd10, 12'd8, 32'd1));
        send_guarded(make_op(CMD_SCATTER, 12'd0, 31'd13, 12'd7, 32'd7));
        send_guarded(make_op(CMD_SCATTER, 12'd0, 31'd10, 12'd0, -32'sd9));
        send_guarded(make_op(CMD_READ, 12'd31, 31'd0, 12'd0, 32'd0));
    endtask

    // Computed addresses at and beyond the end of the table, and a zero slice size.
    task automatic test_address_limits();
        program_table_window(32'd1, 31'd0, 13'd4096, 13'd4096);
        send_guarded(make_op(CMD_SCATTER, 12'd0, 31'd0, 12'd4095, 32'd2));
        send_guarded(make_op(CMD_SCATTER, 12'd0, 31'd1, 12'd0, 32'd2));
        send_guarded(make_op(CMD_SCATTER, 12'd0, 31'd4095, 12'd4095, 32'd2));
        program_table_window(32'd1, 31'd0, 13'd4096, 13'd0);
        send_guarded(make_op(CMD_SCATTER, 12'd0, 31'd0, 12'd0, 32'd2));
    endtask

    // Most negative and most positive scale, with a window at the top slice index.
    task automatic test_scale_extremes();
        program_table_window(32'h8000_0000, 31'h7FFF_FFFF, 13'd1, 13'd16);
        send_guarded(make_op(CMD_SCATTER, 12'd0, 31'h7FFF_FFFF, 12'd3, 32'hFFFF_FFFF));
        send_guarded(make_op(CMD_SCATTER, 12'd0, 31'd0, 12'd3, 32'd1));
        program_table_window(32'h7FFF_FFFF, 31'd0, 13'd4096, 13'd1);
        send_guarded(make_op(CMD_SCATTER, 12'd0, 31'd100, 12'd0, 32'h7FFF_FFFF));
        send_guarded(make_op(CMD_READ, 12'd100, 31'd0, 12'd0, 32'd0));
    endtask

    // Random traffic over several windows; each phase pauses once until drained.
    task automatic test_random_traffic();
        int unsigned words;
        int unsigned slices;
        int unsigned pause_at;
        logic [31:0] r;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: program_table_window(32'h7FFF_FFFF, 31'd0, 13'd4096, 13'd1);
                1: program_table_window(32'h8000_0000, 31'h7FFF_FFFF, 13'd64, 13'd64);
                2: program_table_window(32'hFFFF_FFFF, 31'd3, 13'd4096, 13'd4096);
                default: begin
                    words = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 64);
                    slices = $urandom_range(1, 4096 / ((words == 0) ? 1 : words) + 4);
                    if (slices > 4096) slices = 4096;
                    r = $urandom;
                    if ($urandom_range(0, 1) == 0) r = $urandom_range(0, 1000);
                    program_table_window(draw_value(), r[30:0], 13'(slices), 13'(words));
                end
            endcase
            pause_at = $urandom_range(50, 150);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i == pause_at) wait_drained();
                send_guarded(draw_table_op());
            end
        end
    endtask

    // The result side holds off for a long stretch while items keep coming.
    task automatic test_output_backpressure();
        program_table_window(32'd5, 31'd1000, 13'd32, 13'd32);
        hold_request = 1'b1;
        tx_flood     = 1'b1;
        for (int i = 0; i < FLOOD_ITEMS; i++) send_guarded(draw_table_op());
        tx_flood = 1'b0;
        wait_drained();
    endtask

    // Result side: a random stall before each item, and a long hold on request.
    initial begin : result_sink
        int unsigned stall;
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end
            stall = rx_burst ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready) && !hold_request);
            if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        end
    end

    // Compares each result with the oldest expectation.
    always @(posedge aclk) begin : check_replies
        table_reply_t want;
        bit           bad;
        bit           stray;
        if (aresetn && m_valid && m_ready) begin
            want  = '0;
            stray = (expected_replies.size() == 0);
            if (!stray) want = expected_replies.pop_front();
            bad = stray || (m_read_word !== want.read_word) ||
                  (m_status_code !== want.status_code);
            if (bad) begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display("result %0d%s: expected word %0d status %0d, got word %0d status %0d",
                             reply_count, stray ? " (none expected)" : "", want.read_word,
                             want.status_code, m_read_word, m_status_code);
            end
            reply_count++;
        end
    end

    // Ends the run if no channel moves an item for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("windowed_scaled_scatter_add_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        aresetn            <= 1'b0;
        s_valid            <= 1'b0;
        s_cmd              <= CMD_WRITE;
        s_word_address     <= '0;
        s_slice_index      <= '0;
        s_element_position <= '0;
        s_data_value       <= '0;
        cfg_valid          <= 1'b0;
        cfg_index          <= CFG_SCALE_FACTOR;
        cfg_data           <= '0;
        cfg_shadow.scale_factor  = 32'd1;
        cfg_shadow.window_start  = '0;
        cfg_shadow.window_slices = '0;
        cfg_shadow.slice_words   = 13'd1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_table_access();
        test_window_edges();
        test_address_limits();
        test_scale_extremes();
        test_random_traffic();
        test_output_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("windowed_scaled_scatter_add_tb: done, clean");
        else
            $display("windowed_scaled_scatter_add_tb: done, errors");
        $finish;
    end

endmodule
